[rtl/backslash_escape_decoder_assert.svh]
// Assertion macros for the escape decoder.
// Each macro samples on clk and holds off while rst_n is low.
`ifndef BACKSLASH_ESCAPE_DECODER_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BSED_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BSED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BSED_ASSERT_IMPL(label, ante, cons, msg)

`define BSED_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/bsed_pkg.sv]
package bsed_pkg;

    localparam int CODE_W = 21;
    localparam int MAX_RES = 3;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_ARG  = 2'd1,
        OP_END  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_NEWLINE = 2'd0,
        REG_SPACE   = 2'd1,
        REG_ESCAPE  = 2'd2
    } reg_index_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_BS     = 5'b00010,
        PH_OCT    = 5'b00100,
        PH_XSTART = 5'b01000,
        PH_HEX    = 5'b10000
    } esc_phase_t;

    localparam logic [CODE_W-1:0] CH_NUL       = 21'h00;
    localparam logic [CODE_W-1:0] CH_NEWLINE   = 21'h0A;
    localparam logic [CODE_W-1:0] CH_SPACE     = 21'h20;
    localparam logic [CODE_W-1:0] CH_ZERO      = 21'h30;
    localparam logic [CODE_W-1:0] CH_SEVEN     = 21'h37;
    localparam logic [CODE_W-1:0] CH_NINE      = 21'h39;
    localparam logic [CODE_W-1:0] CH_UPPER_A   = 21'h41;
    localparam logic [CODE_W-1:0] CH_UPPER_F   = 21'h46;
    localparam logic [CODE_W-1:0] CH_BACKSLASH = 21'h5C;
    localparam logic [CODE_W-1:0] CH_LOWER_A   = 21'h61;
    localparam logic [CODE_W-1:0] CH_LOWER_B   = 21'h62;
    localparam logic [CODE_W-1:0] CH_LOWER_C   = 21'h63;
    localparam logic [CODE_W-1:0] CH_LOWER_E   = 21'h65;
    localparam logic [CODE_W-1:0] CH_LOWER_F   = 21'h66;
    localparam logic [CODE_W-1:0] CH_LOWER_N   = 21'h6E;
    localparam logic [CODE_W-1:0] CH_LOWER_R   = 21'h72;
    localparam logic [CODE_W-1:0] CH_LOWER_T   = 21'h74;
    localparam logic [CODE_W-1:0] CH_LOWER_V   = 21'h76;
    localparam logic [CODE_W-1:0] CH_LOWER_X   = 21'h78;

    localparam logic [CODE_W-1:0] CODE_BEL = 21'h07;
    localparam logic [CODE_W-1:0] CODE_BS  = 21'h08;
    localparam logic [CODE_W-1:0] CODE_TAB = 21'h09;
    localparam logic [CODE_W-1:0] CODE_VT  = 21'h0B;
    localparam logic [CODE_W-1:0] CODE_FF  = 21'h0C;
    localparam logic [CODE_W-1:0] CODE_CR  = 21'h0D;
    localparam logic [CODE_W-1:0] CODE_ESC = 21'h1B;

    localparam logic [2:0] LIMIT_OCT_ZERO = 3'd4;
    localparam logic [2:0] LIMIT_OCT      = 3'd3;
    localparam logic [2:0] LIMIT_HEX      = 3'd2;

    typedef struct packed {
        logic newline_en;
        logic space_en;
        logic escape_en;
    } cfg_t;

    typedef struct packed {
        esc_phase_t  phase;
        logic [7:0]  value;
        logic [2:0]  taken;
        logic [2:0]  limit;
        logic        stopped;
        logic        seen;
    } cmd_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] value;
        logic              raw;
    } res_t;

    // {valid, digit}; hex selects base 16, else base 8
    function automatic logic [4:0] digit_of(logic [CODE_W-1:0] c, logic hex);
        logic [CODE_W-1:0] diff;
        logic              ok;
        diff = '0;
        ok   = 1'b0;
        if (c inside {[CH_ZERO:CH_NINE]})
        begin
            diff = c - CH_ZERO;
            ok   = hex || (c <= CH_SEVEN);
        end
        else if (c inside {[CH_LOWER_A:CH_LOWER_F]})
        begin
            diff = c - CH_LOWER_A + 21'd10;
            ok   = hex;
        end
        else if (c inside {[CH_UPPER_A:CH_UPPER_F]})
        begin
            diff = c - CH_UPPER_A + 21'd10;
            ok   = hex;
        end
        return {ok, diff[3:0]};
    endfunction

    // {valid, code} for single-letter escapes
    function automatic logic [CODE_W:0] simple_escape(logic [CODE_W-1:0] c);
        logic [CODE_W:0] r;
        case (c)
            CH_LOWER_A:   r = {1'b1, CODE_BEL};
            CH_LOWER_B:   r = {1'b1, CODE_BS};
            CH_LOWER_E:   r = {1'b1, CODE_ESC};
            CH_LOWER_F:   r = {1'b1, CODE_FF};
            CH_LOWER_N:   r = {1'b1, CH_NEWLINE};
            CH_LOWER_R:   r = {1'b1, CODE_CR};
            CH_LOWER_T:   r = {1'b1, CODE_TAB};
            CH_LOWER_V:   r = {1'b1, CODE_VT};
            CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
            default:      r = {1'b0, CH_NUL};
        endcase
        return r;
    endfunction

endpackage

[rtl/bsed_channels.sv]
interface bsed_in_if;
    import bsed_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [CODE_W-1:0] char_code;

    modport source (output valid, output operation, output char_code, input ready);
    modport sink (input valid, input operation, input char_code, output ready);
endinterface

interface bsed_out_if;
    import bsed_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] out_value;
    logic              raw_byte;
    logic              last;

    modport source (output valid, output out_value, output raw_byte, output last,
                    input ready);
    modport sink (input valid, input out_value, input raw_byte, input last,
                  output ready);
endinterface

[rtl/bsed_step.sv]
module bsed_step
    import bsed_pkg::*;
(
    input  cmd_state_t        st,
    input  cfg_t              cfg,
    input  logic [1:0]        op,
    input  logic [CODE_W-1:0] chr,
    output cmd_state_t        st_next,
    output logic [1:0]        res_count,
    output res_t [2:0]        res
);

    logic [4:0]        dg_oct;
    logic [4:0]        dg_hex;
    logic [CODE_W:0]   simple;
    logic [1:0]        fl_n;
    res_t              fl0;
    res_t              fl1;
    logic              is_hex;
    logic [4:0]        dg;
    logic [7:0]        new_value;
    logic [2:0]        new_taken;
    cmd_state_t        ns;
    logic [1:0]        n;

    assign dg_oct = digit_of(chr, 1'b0);
    assign dg_hex = digit_of(chr, 1'b1);
    assign simple = simple_escape(chr);

    // what a pending escape turns into when cut short
    always_comb
    begin
        fl_n = 2'd0;
        fl0  = '{value: CH_BACKSLASH, raw: 1'b0};
        fl1  = '{value: CH_LOWER_X, raw: 1'b0};
        case (st.phase)
            PH_BS:     fl_n = 2'd1;
            PH_XSTART: fl_n = 2'd2;
            PH_OCT, PH_HEX:
            begin
                fl_n = 2'd1;
                fl0  = '{value: {13'd0, st.value}, raw: 1'b1};
            end
            default:   fl_n = 2'd0;
        endcase
    end

    always_comb
    begin
        ns        = st;
        n         = 2'd0;
        res       = '0;
        is_hex    = (st.phase == PH_HEX);
        dg        = is_hex ? dg_hex : dg_oct;
        new_value = is_hex ? ({st.value[3:0], 4'd0} + {4'd0, dg[3:0]})
                           : ({st.value[4:0], 3'd0} + {4'd0, dg[3:0]});
        new_taken = st.taken + 3'd1;
        case (op)
            OP_CHAR:
            begin
                if (!st.stopped)
                begin
                    case (st.phase)
                        PH_BS:
                        begin
                            ns.phase = PH_IDLE;
                            if (simple[CODE_W])
                            begin
                                res[0] = '{value: simple[CODE_W-1:0], raw: 1'b0};
                                n      = 2'd1;
                            end
                            else if (chr == CH_LOWER_C)
                            begin
                                ns.stopped = 1'b1;
                            end
                            else if (chr == CH_LOWER_X)
                            begin
                                ns.phase = PH_XSTART;
                            end
                            else if (dg_oct[4])
                            begin
                                ns.phase = PH_OCT;
                                ns.value = {4'd0, dg_oct[3:0]};
                                ns.taken = 3'd1;
                                ns.limit = (chr == CH_ZERO) ? LIMIT_OCT_ZERO : LIMIT_OCT;
                            end
                            else
                            begin
                                res[0] = '{value: CH_BACKSLASH, raw: 1'b0};
                                n      = 2'd1;
                                if (cfg.escape_en && chr == CH_BACKSLASH)
                                begin
                                    ns.phase = PH_BS;
                                end
                                else
                                begin
                                    res[n] = '{value: chr, raw: 1'b0};
                                    n      = n + 2'd1;
                                end
                            end
                        end
                        PH_OCT, PH_HEX, PH_XSTART:
                        begin
                            if (st.phase == PH_XSTART && dg_hex[4])
                            begin
                                ns.phase = PH_HEX;
                                ns.value = {4'd0, dg_hex[3:0]};
                                ns.taken = 3'd1;
                                ns.limit = LIMIT_HEX;
                            end
                            else if (st.phase != PH_XSTART && dg[4] && st.taken < st.limit)
                            begin
                                if (new_taken >= st.limit)
                                begin
                                    res[0]   = '{value: {13'd0, new_value}, raw: 1'b1};
                                    n        = 2'd1;
                                    ns.phase = PH_IDLE;
                                    ns.value = 8'd0;
                                    ns.taken = 3'd0;
                                    ns.limit = 3'd0;
                                end
                                else
                                begin
                                    ns.value = new_value;
                                    ns.taken = new_taken;
                                end
                            end
                            else
                            begin
                                res[0]   = fl0;
                                res[1]   = fl1;
                                n        = fl_n;
                                ns.phase = PH_IDLE;
                                ns.value = 8'd0;
                                ns.taken = 3'd0;
                                ns.limit = 3'd0;
                                if (cfg.escape_en && chr == CH_BACKSLASH)
                                begin
                                    ns.phase = PH_BS;
                                end
                                else
                                begin
                                    res[n] = '{value: chr, raw: 1'b0};
                                    n      = n + 2'd1;
                                end
                            end
                        end
                        default:
                        begin
                            ns.phase = PH_IDLE;
                            if (cfg.escape_en && chr == CH_BACKSLASH)
                            begin
                                ns.phase = PH_BS;
                            end
                            else
                            begin
                                res[0] = '{value: chr, raw: 1'b0};
                                n      = 2'd1;
                            end
                        end
                    endcase
                end
            end
            OP_ARG:
            begin
                if (!st.stopped)
                begin
                    res[0]   = fl0;
                    res[1]   = fl1;
                    n        = fl_n;
                    ns.phase = PH_IDLE;
                    ns.value = 8'd0;
                    ns.taken = 3'd0;
                    ns.limit = 3'd0;
                    if (st.seen && cfg.space_en)
                    begin
                        res[n] = '{value: CH_SPACE, raw: 1'b0};
                        n      = n + 2'd1;
                    end
                    ns.seen = 1'b1;
                end
            end
            OP_END:
            begin
                if (!st.stopped)
                begin
                    res[0] = fl0;
                    res[1] = fl1;
                    n      = fl_n;
                    if (cfg.newline_en)
                    begin
                        res[n] = '{value: CH_NEWLINE, raw: 1'b0};
                        n      = n + 2'd1;
                    end
                end
                ns = '{phase: PH_IDLE, value: 8'd0, taken: 3'd0, limit: 3'd0,
                       stopped: 1'b0, seen: 1'b0};
            end
            default:
            begin
                ns = st;
            end
        endcase
        st_next   = ns;
        res_count = n;
    end

endmodule

[rtl/backslash_escape_decoder.sv]
// channel   | dir | payload                          | handshake
// ----------+-----+----------------------------------+-------------------
// items     | in  | operation, char_code             | valid / ready
// chars     | out | out_value, raw_byte, last        | valid / ready
// cfg       | in  | cfg_write_en, cfg_index, cfg_data | write only
//
// One item per cycle while the buffer has room; items pass a holding stage to the buffer.
// Two or three characters from one item hold the next item back until the last is taken.
// The result buffer drains one character per cycle while ready; items stall only behind it.
// Reset clears the command state and loads newline and space on, escapes off.
`include "backslash_escape_decoder_assert.svh"

module backslash_escape_decoder
    import bsed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bsed_in_if.sink    items,
    bsed_out_if.source chars,
    input  logic       cfg_write_en,
    input  logic [1:0] cfg_index,
    input  logic [0:0] cfg_data
);

    cfg_t              cfg_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [1:0]        s1_op_reg;
    logic [CODE_W-1:0] s1_char_reg;
    cmd_state_t        st_reg;
    cmd_state_t        st_next;
    logic [1:0]        rem_reg;
    logic [1:0]        rem_next;
    res_t [2:0]        slot_reg;
    res_t [2:0]        slot_next;
    logic [1:0]        res_count;
    res_t [2:0]        res;
    logic              buf_free;
    logic              load;
    logic              in_xfer;
    logic              out_xfer;

    bsed_step u_step (
        .st        (st_reg),
        .cfg       (cfg_reg),
        .op        (s1_op_reg),
        .chr       (s1_char_reg),
        .st_next   (st_next),
        .res_count (res_count),
        .res       (res)
    );

    assign out_xfer     = chars.valid && chars.ready;
    assign buf_free     = (rem_reg == 2'd0) || (rem_reg == 2'd1 && chars.ready);
    assign load         = s1_valid_reg && buf_free;
    assign items.ready  = !s1_valid_reg || load;
    assign in_xfer      = items.valid && items.ready;

    assign chars.valid     = (rem_reg != 2'd0);
    assign chars.out_value = slot_reg[0].value;
    assign chars.raw_byte  = slot_reg[0].raw;
    assign chars.last      = (rem_reg == 2'd1);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // load a fresh result set, or advance the queue by one
    always_comb
    begin
        rem_next  = rem_reg;
        slot_next = slot_reg;
        if (load)
        begin
            rem_next  = res_count;
            slot_next = res;
        end
        else if (out_xfer)
        begin
            rem_next  = rem_reg - 2'd1;
            slot_next = {slot_reg[2], slot_reg[2], slot_reg[1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '{newline_en: 1'b1, space_en: 1'b1, escape_en: 1'b0};
            s1_valid_reg <= 1'b0;
            rem_reg      <= 2'd0;
            st_reg       <= '{phase: PH_IDLE, value: 8'd0, taken: 3'd0, limit: 3'd0,
                              stopped: 1'b0, seen: 1'b0};
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            rem_reg      <= rem_next;
            if (load)
            begin
                st_reg <= st_next;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_NEWLINE: cfg_reg.newline_en <= cfg_data[0];
                    REG_SPACE:   cfg_reg.space_en   <= cfg_data[0];
                    REG_ESCAPE:  cfg_reg.escape_en  <= cfg_data[0];
                    default:     cfg_reg            <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg   <= items.operation;
            s1_char_reg <= items.char_code;
        end
        slot_reg <= slot_next;
    end

    `BSED_ASSERT_IMPL(a_stopped_silent, load && st_reg.stopped, res_count == 2'd0, "output while stopped")
    `BSED_ASSERT_NEXT(a_drain_empty, out_xfer && chars.last && !load, !chars.valid, "stale result after last")
    `BSED_ASSERT_NEXT(a_hold_item, s1_valid_reg && !load, s1_valid_reg && $stable(s1_char_reg), "held item lost")
    `BSED_ASSERT_NEXT(a_end_clears, load && s1_op_reg == OP_END, !st_reg.stopped && !st_reg.seen, "command state kept")

endmodule

[tb/backslash_escape_decoder_tb.sv]
module backslash_escape_decoder_tb;
    import bsed_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 20;
    localparam int BREAK_PCT    = 36;

    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam logic [CODE_W-1:0] CODE_MAX   = 21'h1FFFFF;
    localparam logic [CODE_W-1:0] CH_ONE     = 21'h31;
    localparam logic [CODE_W-1:0] CH_UPPER_Z = 21'h5A;
    localparam logic [CODE_W-1:0] CH_LOWER_G = 21'h67;
    localparam logic [CODE_W-1:0] CH_LOWER_Q = 21'h71;
    localparam logic [CODE_W-1:0] CH_LOWER_Z = 21'h7A;

    typedef struct packed {
        logic [CODE_W-1:0] value;
        logic              raw;
        logic              last;
    } char_t;

    typedef struct {
        bit                is_cfg;
        logic [1:0]        sel;
        logic [CODE_W-1:0] code;
        bit                typed;
        int                nexp;
        logic [CODE_W-1:0] val;
        bit                raw;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write_en;
    logic [1:0] cfg_index;
    logic [0:0] cfg_data;

    bsed_in_if  item_ch();
    bsed_out_if chars_ch();

    backslash_escape_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (item_ch),
        .chars        (chars_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // decoder model state
    bit         newline_on = 1'b1;
    bit         space_on   = 1'b1;
    bit         escape_on  = 1'b0;
    esc_phase_t esc_phase  = PH_IDLE;
    logic [7:0] esc_byte   = '0;
    logic [2:0] digit_count = '0;
    logic [2:0] digit_max  = '0;
    bit         halted     = 1'b0;
    bit         arg_open   = 1'b0;

    char_t     step_chars[$];
    char_t     awaited_chars[$];
    stim_row_t directed_rows[$];

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int items_sent = 0;
    int commands_ended = 0;
    int settings_written = 0;
    int chars_checked = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < BREAK_PCT);
    endfunction

    function automatic int digit_value(logic [CODE_W-1:0] c, int base);
        int d;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = int'(c - CH_ZERO);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            d = int'(c - CH_LOWER_A) + 10;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            d = int'(c - CH_UPPER_A) + 10;
        else
            d = -1;
        return (d < base) ? d : -1;
    endfunction

    function automatic void add_row(stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void await_char(char_t r);
        awaited_chars.insert(awaited_chars.size(), r);
    endfunction

    function automatic void put_char(logic [CODE_W-1:0] v, logic raw);
        char_t r;
        r.value = v;
        r.raw   = raw;
        r.last  = 1'b0;
        if (step_chars.size() < MAX_RES)
            step_chars.insert(step_chars.size(), r);
    endfunction

    function automatic void literal_char(logic [CODE_W-1:0] c);
        if (escape_on && c == CH_BACKSLASH)
            esc_phase = PH_BS;
        else
            put_char(c, 1'b0);
    endfunction

    // emit whatever a pending escape stands for, then go idle
    function automatic void close_escape();
        case (esc_phase)
            PH_BS:
                put_char(CH_BACKSLASH, 1'b0);
            PH_XSTART:
            begin
                put_char(CH_BACKSLASH, 1'b0);
                put_char(CH_LOWER_X, 1'b0);
            end
            PH_OCT, PH_HEX:
                put_char(CODE_W'(esc_byte), 1'b1);
            default: ;
        endcase
        esc_phase   = PH_IDLE;
        esc_byte    = '0;
        digit_count = '0;
        digit_max   = '0;
    endfunction

    function automatic void add_digit(logic [CODE_W-1:0] c, int base);
        int d;
        d = digit_value(c, base);
        if (d >= 0 && digit_count < digit_max)
        begin
            esc_byte    = 8'(int'(esc_byte) * base + d);
            digit_count = digit_count + 3'd1;
            if (digit_count >= digit_max)
                close_escape();
        end
        else
        begin
            close_escape();
            literal_char(c);
        end
    endfunction

    function automatic void decode_char(logic [CODE_W-1:0] c);
        int d;
        case (esc_phase)
            PH_BS:
            begin
                esc_phase = PH_IDLE;
                case (c)
                    CH_LOWER_A:   put_char(CODE_BEL, 1'b0);
                    CH_LOWER_B:   put_char(CODE_BS, 1'b0);
                    CH_LOWER_E:   put_char(CODE_ESC, 1'b0);
                    CH_LOWER_F:   put_char(CODE_FF, 1'b0);
                    CH_LOWER_N:   put_char(CH_NEWLINE, 1'b0);
                    CH_LOWER_R:   put_char(CODE_CR, 1'b0);
                    CH_LOWER_T:   put_char(CODE_TAB, 1'b0);
                    CH_LOWER_V:   put_char(CODE_VT, 1'b0);
                    CH_BACKSLASH: put_char(CH_BACKSLASH, 1'b0);
                    CH_LOWER_C:   halted = 1'b1;
                    CH_LOWER_X:   esc_phase = PH_XSTART;
                    default:
                    begin
                        d = digit_value(c, 8);
                        if (d >= 0)
                        begin
                            esc_phase   = PH_OCT;
                            esc_byte    = 8'(d);
                            digit_count = 3'd1;
                            digit_max   = (c == CH_ZERO) ? LIMIT_OCT_ZERO : LIMIT_OCT;
                        end
                        else
                        begin
                            put_char(CH_BACKSLASH, 1'b0);
                            literal_char(c);
                        end
                    end
                endcase
            end
            PH_OCT:
                add_digit(c, 8);
            PH_XSTART:
            begin
                d = digit_value(c, 16);
                if (d >= 0)
                begin
                    esc_phase   = PH_HEX;
                    esc_byte    = 8'(d);
                    digit_count = 3'd1;
                    digit_max   = LIMIT_HEX;
                end
                else
                begin
                    close_escape();
                    literal_char(c);
                end
            end
            PH_HEX:
                add_digit(c, 16);
            default:
            begin
                esc_phase = PH_IDLE;
                literal_char(c);
            end
        endcase
    endfunction

    function automatic void decode_item(logic [1:0] op, logic [CODE_W-1:0] c);
        step_chars.delete();
        case (op)
            OP_CHAR:
                if (!halted)
                    decode_char(c);
            OP_ARG:
                if (!halted)
                begin
                    close_escape();
                    if (arg_open && space_on)
                        put_char(CH_SPACE, 1'b0);
                    arg_open = 1'b1;
                end
            OP_END:
            begin
                if (!halted)
                begin
                    close_escape();
                    if (newline_on)
                        put_char(CH_NEWLINE, 1'b0);
                end
                close_escape();
                halted   = 1'b0;
                arg_open = 1'b0;
            end
            default: ;
        endcase
        if (step_chars.size() > 0)
            step_chars[step_chars.size() - 1].last = 1'b1;
    endfunction

    function automatic stim_row_t make_item(logic [1:0] op, logic [CODE_W-1:0] code);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.sel    = op;
        r.code   = code;
        r.typed  = 1'b0;
        r.nexp   = 0;
        r.val    = '0;
        r.raw    = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t make_typed(logic [1:0] op, logic [CODE_W-1:0] code,
                                             int nexp, logic [CODE_W-1:0] val, bit raw);
        stim_row_t r;
        r       = make_item(op, code);
        r.typed = 1'b1;
        r.nexp  = nexp;
        r.val   = val;
        r.raw   = raw;
        return r;
    endfunction

    function automatic stim_row_t make_setting(reg_index_t idx, bit data);
        stim_row_t r;
        r        = make_item(idx, CODE_W'(data));
        r.is_cfg = 1'b1;
        return r;
    endfunction

    // drop valid, let the decoder drain and settle, then write one register
    task automatic write_setting(reg_index_t idx, bit data);
        item_ch.valid <= 1'b0;
        while (awaited_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_NEWLINE: newline_on = data;
            REG_SPACE:   space_on   = data;
            REG_ESCAPE:  escape_on  = data;
            default: ;
        endcase
        settings_written++;
    endtask

    task automatic send_item(stim_row_t row);
        char_t r;
        while (take_break())
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= row.sel;
        item_ch.char_code <= row.code;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        decode_item(row.sel, row.code);
        if (row.typed)
        begin
            if (row.nexp > 0)
            begin
                r.value = row.val;
                r.raw   = row.raw;
                r.last  = 1'b1;
                await_char(r);
            end
        end
        else
        begin
            foreach (step_chars[i])
                await_char(step_chars[i]);
        end
        items_sent++;
        if (row.sel == OP_END)
            commands_ended++;
    endtask

    // receiver: check every transfer, drive ready
    initial
    begin
        char_t want;
        chars_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && chars_ch.valid && chars_ch.ready)
            begin
                if (awaited_chars.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected char: value %h raw %b last %b",
                                 chars_ch.out_value, chars_ch.raw_byte, chars_ch.last);
                end
                else
                begin
                    want = awaited_chars.pop_front();
                    chars_checked++;
                    if (chars_ch.out_value !== want.value || chars_ch.raw_byte !== want.raw
                        || chars_ch.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected %h raw %b last %b, got %h raw %b last %b",
                                     want.value, want.raw, want.last, chars_ch.out_value,
                                     chars_ch.raw_byte, chars_ch.last);
                    end
                end
            end
            if (hold_request && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                chars_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                chars_ch.ready <= !take_break();
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (chars_ch.valid && chars_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [2:0]        mode;
        int                phase_start;
        int                n_args;
        int                n_chars;
        int unsigned       roll;
        logic [CODE_W-1:0] code;
        int                missing;

        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.operation = OP_CHAR;
        item_ch.char_code = '0;
        cfg_write_en      = 1'b0;
        cfg_index         = REG_NEWLINE;
        cfg_data          = '0;

        // reset settings: newline and space on, escapes off
        add_row(make_typed(OP_ARG, CODE_MAX, 0, CH_NUL, 1'b0));
        add_row(make_typed(OP_CHAR, CH_NUL, 1, CH_NUL, 1'b0));
        add_row(make_typed(OP_CHAR, CODE_MAX, 1, CODE_MAX, 1'b0));
        add_row(make_typed(OP_CHAR, CH_BACKSLASH, 1, CH_BACKSLASH, 1'b0));
        add_row(make_typed(OP_ARG, CH_NUL, 1, CH_SPACE, 1'b0));
        add_row(make_typed(OP_IGNORED, CODE_MAX, 0, CH_NUL, 1'b0));
        add_row(make_typed(OP_END, CH_NUL, 1, CH_NEWLINE, 1'b0));
        add_row(make_setting(REG_ESCAPE, 1'b1));
        add_row(make_typed(OP_CHAR, CH_BACKSLASH, 0, CH_NUL, 1'b0));
        add_row(make_typed(OP_CHAR, CH_LOWER_N, 1, CH_NEWLINE, 1'b0));
        // unknown escape
        add_row(make_item(OP_CHAR, CH_BACKSLASH));
        add_row(make_item(OP_CHAR, CH_LOWER_Q));
        // backslash x with no hex digit
        add_row(make_item(OP_CHAR, CH_BACKSLASH));
        add_row(make_item(OP_CHAR, CH_LOWER_X));
        add_row(make_item(OP_CHAR, CH_LOWER_G));
        // octal with leading zero takes four digits
        add_row(make_item(OP_CHAR, CH_BACKSLASH));
        add_row(make_item(OP_CHAR, CH_ZERO));
        add_row(make_item(OP_CHAR, CH_ONE));
        add_row(make_item(OP_CHAR, CH_SEVEN));
        add_row(make_item(OP_CHAR, CH_SEVEN));
        // pending hex escape flushed by an argument start
        add_row(make_item(OP_CHAR, CH_BACKSLASH));
        add_row(make_item(OP_CHAR, CH_LOWER_X));
        add_row(make_item(OP_CHAR, CH_UPPER_F));
        add_row(make_item(OP_ARG, CH_NUL));
        // stop output, end of command yields nothing
        add_row(make_item(OP_CHAR, CH_BACKSLASH));
        add_row(make_item(OP_CHAR, CH_LOWER_C));
        add_row(make_item(OP_CHAR, CH_LOWER_A));
        add_row(make_item(OP_END, CODE_MAX));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_setting(reg_index_t'(directed_rows[i].sel), directed_rows[i].code[0]);
            else
                send_item(directed_rows[i]);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: mode = 3'b111;
                1: mode = 3'b001;
                2: mode = 3'b000;
                3: mode = 3'b101;
                4: mode = 3'($urandom_range(7));
                default: mode = 3'b011;
            endcase
            write_setting(REG_NEWLINE, mode[2]);
            write_setting(REG_SPACE, mode[1]);
            write_setting(REG_ESCAPE, mode[0]);
            // full rate with the receiver held off at the start
            calm = (p == 1);
            if (p == 1)
                hold_request = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                n_args = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
                for (int a = 0; a <= n_args; a++)
                begin
                    if (a > 0)
                        send_item(make_item(OP_ARG, CODE_W'($urandom_range(0, CODE_MAX))));
                    if (a == 0)
                        n_chars = ($urandom_range(9) == 0) ? 2 : 0;
                    else
                        n_chars = $urandom_range(0, 6);
                    for (int k = 0; k < n_chars; k++)
                    begin
                        roll = $urandom_range(99);
                        if (roll < 28)
                            code = CH_BACKSLASH;
                        else if (roll < 48)
                        begin
                            case ($urandom_range(10))
                                0: code = CH_LOWER_A;
                                1: code = CH_LOWER_B;
                                2: code = CH_LOWER_E;
                                3: code = CH_LOWER_F;
                                4: code = CH_LOWER_N;
                                5: code = CH_LOWER_R;
                                6: code = CH_LOWER_T;
                                7: code = CH_LOWER_V;
                                8: code = CH_LOWER_X;
                                9: code = CH_LOWER_Q;
                                default: code = CH_LOWER_C;
                            endcase
                        end
                        else if (roll < 66)
                            code = CODE_W'(CH_ZERO + $urandom_range(9));
                        else if (roll < 76)
                            code = CODE_W'(($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A)
                                           + $urandom_range(6));
                        else if (roll < 88)
                            code = CODE_W'($urandom_range(32, 126));
                        else if (roll < 97)
                            code = CODE_W'($urandom_range(0, CODE_MAX));
                        else
                            code = $urandom_range(1) ? CH_NUL : CODE_MAX;
                        if ($urandom_range(99) < 3)
                            send_item(make_item(OP_IGNORED, code));
                        else
                            send_item(make_item(OP_CHAR, code));
                    end
                end
                // now and then leave the command open across a settings change
                if ($urandom_range(99) < 90)
                    send_item(make_item(OP_END, CODE_W'($urandom_range(0, CODE_MAX))));
            end
            calm = 1'b0;
        end

        item_ch.valid <= 1'b0;
        while (awaited_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        missing = awaited_chars.size();
        if (missing != 0)
            $display("%0d expected chars never arrived", missing);
        $display("Sent %0d items in %0d commands under %0d register writes.",
                 items_sent, commands_ended, settings_written);
        $display("Checked %0d output chars; %0d failures.", chars_checked,
                 mismatches + missing);
        if (mismatches + missing == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
